// ===== hdl/page_buffer_slot_manager_top_macros.svh =====
// Assertion macros for the page slot manager.
`ifndef PAGE_BUFFER_SLOT_MANAGER_TOP_MACROS_SVH
`define PAGE_BUFFER_SLOT_MANAGER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define PBSM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pbsm: check failed");
`define PBSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbsm: sequence check failed");
`else
`define PBSM_ASSERT(lbl, prop)
`define PBSM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/pbsm_pkg.sv =====
`default_nettype none

package pbsm_pkg;

  localparam int unsigned SLOTS   = 8;
  localparam int unsigned SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOTF_W = 3;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_DIRTY   = 2'd1,
    ACT_RELEASE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_FULL     = 3'd2,
    ST_DONE     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // state change for one slot
  typedef struct packed {
    logic      en;
    slot_idx_t idx;
    logic      load;       // take new page address, set valid
    logic      pin_we;
    logic      pin_val;
    logic      dirty_we;
    logic      dirty_val;
  } slot_upd_t;

  typedef struct packed {
    status_e             status;
    logic [SLOTF_W-1:0]  slot;
    logic                fetch;
    logic                writeback;
    addr_t               writeback_addr;
  } result_t;

  // low bits of a slot index for the result field
  function automatic logic [SLOTF_W-1:0] slot_field(slot_idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOTF_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pbsm_slots.sv =====
`default_nettype none

module pbsm_slots (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pbsm_pkg::slot_upd_t upd_i,
  input  wire pbsm_pkg::addr_t     addr_i,
  output logic [pbsm_pkg::SLOTS-1:0] valid_o,
  output logic [pbsm_pkg::SLOTS-1:0] pinned_o,
  output logic [pbsm_pkg::SLOTS-1:0] dirty_o,
  output pbsm_pkg::addr_t          page_addr_o [pbsm_pkg::SLOTS]
);

  logic [pbsm_pkg::SLOTS-1:0] valid_q, pinned_q, dirty_q;
  pbsm_pkg::addr_t            page_addr_q [pbsm_pkg::SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      pinned_q <= '0;
      dirty_q  <= '0;
    end else if (upd_i.en) begin
      if (upd_i.load)     valid_q[upd_i.idx]  <= 1'b1;
      if (upd_i.pin_we)   pinned_q[upd_i.idx] <= upd_i.pin_val;
      if (upd_i.dirty_we) dirty_q[upd_i.idx]  <= upd_i.dirty_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.load) begin
      page_addr_q[upd_i.idx] <= addr_i;
    end
  end

  assign valid_o     = valid_q;
  assign pinned_o    = pinned_q;
  assign dirty_o     = dirty_q;
  assign page_addr_o = page_addr_q;

endmodule

`default_nettype wire

// ===== hdl/pbsm_lookup.sv =====
`default_nettype none

module pbsm_lookup (
  input  wire logic [1:0]             action_i,
  input  wire pbsm_pkg::addr_t        addr_i,
  input  wire logic                   go_i,
  input  wire logic [pbsm_pkg::SLOTS-1:0] valid_i,
  input  wire logic [pbsm_pkg::SLOTS-1:0] pinned_i,
  input  wire logic [pbsm_pkg::SLOTS-1:0] dirty_i,
  input  wire pbsm_pkg::addr_t        page_addr_i [pbsm_pkg::SLOTS],
  output logic [pbsm_pkg::SLOTS-1:0]  match_o,
  output pbsm_pkg::result_t           res_o,
  output pbsm_pkg::slot_upd_t         upd_o
);

  logic [pbsm_pkg::SLOTS-1:0] match;
  logic                       hit, free_found;
  pbsm_pkg::slot_idx_t        m_idx, f_idx;
  pbsm_pkg::action_e          act;

  always_comb begin
    for (int i = 0; i < int'(pbsm_pkg::SLOTS); i++) begin
      match[i] = valid_i[i] && (page_addr_i[i] == addr_i);
    end
  end

  // lowest index wins
  always_comb begin
    m_idx      = '0;
    f_idx      = '0;
    free_found = 1'b0;
    for (int i = int'(pbsm_pkg::SLOTS) - 1; i >= 0; i--) begin
      if (match[i]) m_idx = pbsm_pkg::SLOT_W'(i);
      if (!pinned_i[i]) begin
        f_idx      = pbsm_pkg::SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign hit     = |match;
  assign act     = pbsm_pkg::action_e'(action_i);
  assign match_o = match;

  always_comb begin
    res_o = '{status: pbsm_pkg::ST_NOTFOUND, slot: '0, fetch: 1'b0,
              writeback: 1'b0, writeback_addr: '0};
    upd_o = '0;
    unique case (act)
      pbsm_pkg::ACT_GET: begin
        if (hit) begin
          res_o.status  = pbsm_pkg::ST_HIT;
          res_o.slot    = pbsm_pkg::slot_field(m_idx);
          upd_o.en      = go_i;
          upd_o.idx     = m_idx;
          upd_o.pin_we  = 1'b1;
          upd_o.pin_val = 1'b1;
        end else if (free_found) begin
          res_o.status  = pbsm_pkg::ST_MISS;
          res_o.slot    = pbsm_pkg::slot_field(f_idx);
          res_o.fetch   = 1'b1;
          if (valid_i[f_idx] && dirty_i[f_idx]) begin
            res_o.writeback      = 1'b1;
            res_o.writeback_addr = page_addr_i[f_idx];
          end
          upd_o.en       = go_i;
          upd_o.idx      = f_idx;
          upd_o.load     = 1'b1;
          upd_o.pin_we   = 1'b1;
          upd_o.pin_val  = 1'b1;
          upd_o.dirty_we = 1'b1;
        end else begin
          res_o.status = pbsm_pkg::ST_FULL;
        end
      end
      pbsm_pkg::ACT_DIRTY: begin
        if (hit) begin
          res_o.status    = pbsm_pkg::ST_DONE;
          res_o.slot      = pbsm_pkg::slot_field(m_idx);
          upd_o.en        = go_i;
          upd_o.idx       = m_idx;
          upd_o.dirty_we  = 1'b1;
          upd_o.dirty_val = 1'b1;
        end
      end
      pbsm_pkg::ACT_RELEASE: begin
        if (hit) begin
          res_o.status         = pbsm_pkg::ST_DONE;
          res_o.slot           = pbsm_pkg::slot_field(m_idx);
          res_o.writeback      = 1'b1;
          res_o.writeback_addr = addr_i;
          upd_o.en             = go_i;
          upd_o.idx            = m_idx;
          upd_o.pin_we         = 1'b1;
          upd_o.dirty_we       = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/page_buffer_slot_manager_top.sv =====
// channel  dir  beat fields                                        handshake
// in       in   action_i, page_addr_i                              in_valid_i / in_ready_o
// out      out  status_o, slot_o, fetch_o, writeback_o,            out_valid_o / out_ready_i
//               writeback_addr_o
//
// One beat per cycle sustained while the output does not stall; a result reaches the
// outputs through the input register, then the result register.
// Slot state updates on the edge that loads the result register, so the next beat
// sees it. Reset clears valid, pinned and dirty marks at once; no clearing pass.
// An output stall holds the input stage; in_ready_o stays high while it is empty.
`default_nettype none
`include "page_buffer_slot_manager_top_macros.svh"

module page_buffer_slot_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] page_addr_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [2:0]       slot_o,
  output logic             fetch_o,
  output logic             writeback_o,
  output logic [31:0]      writeback_addr_o
);

  logic              in_vld_q;
  logic [1:0]        act_q;
  pbsm_pkg::addr_t   addr_q;
  logic              out_vld_q;
  pbsm_pkg::result_t res_q, res_d;
  logic              adv;

  logic [pbsm_pkg::SLOTS-1:0] valid, pinned, dirty, match;
  pbsm_pkg::addr_t            page_addr [pbsm_pkg::SLOTS];
  pbsm_pkg::slot_upd_t        upd;

  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) in_vld_q <= in_valid_i;
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q  <= action_i;
      addr_q <= page_addr_i;
    end
    if (adv) res_q <= res_d;
  end

  pbsm_lookup u_lookup (
    .action_i    (act_q),
    .addr_i      (addr_q),
    .go_i        (adv),
    .valid_i     (valid),
    .pinned_i    (pinned),
    .dirty_i     (dirty),
    .page_addr_i (page_addr),
    .match_o     (match),
    .res_o       (res_d),
    .upd_o       (upd)
  );

  pbsm_slots u_slots (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (upd),
    .addr_i      (addr_q),
    .valid_o     (valid),
    .pinned_o    (pinned),
    .dirty_o     (dirty),
    .page_addr_o (page_addr)
  );

  assign out_valid_o      = out_vld_q;
  assign status_o         = res_q.status;
  assign slot_o           = res_q.slot;
  assign fetch_o          = res_q.fetch;
  assign writeback_o      = res_q.writeback;
  assign writeback_addr_o = res_q.writeback_addr;

  `PBSM_ASSERT(a_single_match, $onehot0(match))
  `PBSM_ASSERT(a_full_all_pinned,
    !(out_vld_q && res_q.status == pbsm_pkg::ST_FULL) || (&pinned))
  `PBSM_ASSERT(a_miss_fetches,
    !(out_vld_q && res_q.status == pbsm_pkg::ST_MISS) || res_q.fetch)
  `PBSM_ASSERT(a_stall_only_when_full,
    in_ready_o || (in_vld_q && out_vld_q && !out_ready_i))
  `PBSM_ASSERT_NEXT(a_load_pins, upd.en && upd.load, pinned[$past(upd.idx)])

endmodule

`default_nettype wire

// ===== tb/page_buffer_slot_manager_top_test.sv =====
module page_buffer_slot_manager_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pbsm_pkg::*;

  localparam logic [1:0] ACT_UNKNOWN = 2'd3;
  localparam int unsigned POOL_N = 12;

  // table shadow: predicts each answer when its request beat is taken
  class slot_table_tracker;
    logic [31:0] page[SLOTS];
    bit          valid[SLOTS];
    bit          pinned[SLOTS];
    bit          dirty[SLOTS];
    result_t     pending_answers[$];
    int          errors;

    function new();
      foreach (page[i]) begin
        page[i]   = '0;
        valid[i]  = 1'b0;
        pinned[i] = 1'b0;
        dirty[i]  = 1'b0;
      end
      errors = 0;
    endfunction

    function void take_request(logic [1:0] act, logic [31:0] addr);
      result_t r;
      int      hit;
      int      free_idx;
      r = '{status: ST_NOTFOUND, slot: '0, fetch: 1'b0, writeback: 1'b0,
            writeback_addr: '0};
      hit = -1;
      free_idx = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (valid[i] && page[i] == addr) hit = i;
        if (!pinned[i]) free_idx = i;
      end
      case (act)
        ACT_GET: begin
          if (hit >= 0) begin
            pinned[hit] = 1'b1;
            r.status = ST_HIT;
            r.slot = 3'(hit);
          end else if (free_idx < 0) begin
            r.status = ST_FULL;
          end else begin
            if (valid[free_idx] && dirty[free_idx]) begin
              r.writeback = 1'b1;
              r.writeback_addr = page[free_idx];
            end
            page[free_idx]   = addr;
            valid[free_idx]  = 1'b1;
            pinned[free_idx] = 1'b1;
            dirty[free_idx]  = 1'b0;
            r.status = ST_MISS;
            r.slot = 3'(free_idx);
            r.fetch = 1'b1;
          end
        end
        ACT_DIRTY: begin
          if (hit >= 0) begin
            dirty[hit] = 1'b1;
            r.status = ST_DONE;
            r.slot = 3'(hit);
          end
        end
        ACT_RELEASE: begin
          if (hit >= 0) begin
            pinned[hit] = 1'b0;
            dirty[hit]  = 1'b0;
            r.status = ST_DONE;
            r.slot = 3'(hit);
            r.writeback = 1'b1;
            r.writeback_addr = addr;
          end
        end
        default: ;
      endcase
      pending_answers.push_back(r);
    endfunction

    function void check_answer(result_t got);
      result_t want;
      if (pending_answers.size() == 0) begin
        $error("answer with no request pending: status %0d slot %0d", got.status, got.slot);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $error("slot: expected %0d, got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.fetch !== want.fetch) begin
        $error("fetch: expected %0b, got %0b", want.fetch, got.fetch);
        errors++;
      end
      if (got.writeback !== want.writeback) begin
        $error("writeback: expected %0b, got %0b", want.writeback, got.writeback);
        errors++;
      end
      if (got.writeback_addr !== want.writeback_addr) begin
        $error("writeback_addr: expected %h, got %h", want.writeback_addr,
               got.writeback_addr);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  action_i;
  logic [31:0] page_addr_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [2:0]  slot_o;
  logic        fetch_o;
  logic        writeback_o;
  logic [31:0] writeback_addr_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  slot_table_tracker sb;

  page_buffer_slot_manager_top i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .action_i         (action_i),
    .page_addr_i      (page_addr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_o           (slot_o),
    .fetch_o          (fetch_o),
    .writeback_o      (writeback_o),
    .writeback_addr_o (writeback_addr_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_answer('{status: status_e'(status_o), slot: slot_o, fetch: fetch_o,
                        writeback: writeback_o, writeback_addr: writeback_addr_o});
    end
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_beat(input logic [1:0] act, input logic [31:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    page_addr_i <= addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_request(act, addr);
  endtask

  // mostly get/dirty/release on a small set of pages, the rest random noise
  task automatic run_phase(input int n);
    logic [31:0] pool[POOL_N];
    logic [1:0]  act;
    logic [31:0] addr;
    int unsigned pick;
    foreach (pool[k]) pool[k] = $urandom;
    if ($urandom_range(1) == 0) begin
      pool[0] = '0;
      pool[1] = '1;
    end
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        addr = pool[$urandom_range(POOL_N - 1)];
        pick = $urandom_range(99);
        act = (pick < 40) ? ACT_GET : (pick < 65) ? ACT_DIRTY : ACT_RELEASE;
      end else begin
        addr = $urandom;
        act = 2'($urandom_range(3));
      end
      send_beat(act, addr);
    end
  endtask

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_GET;
    page_addr_i = '0;
    out_ready_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unknown action
    send_beat(ACT_RELEASE, 32'h0000_0000);
    send_beat(ACT_DIRTY, 32'hFFFF_FFFF);
    send_beat(ACT_UNKNOWN, 32'hFFFF_FFFF);
    send_beat(ACT_GET, 32'h0000_0000);
    send_beat(ACT_GET, 32'h0000_0000);
    send_beat(ACT_DIRTY, 32'h0000_0000);
    // fill every slot, then one more get
    send_beat(ACT_GET, 32'hFFFF_FFFF);
    send_beat(ACT_GET, 32'h8000_0000);
    send_beat(ACT_GET, 32'h7FFF_FFFF);
    send_beat(ACT_GET, 32'hAAAA_AAAA);
    send_beat(ACT_GET, 32'h5555_5555);
    send_beat(ACT_GET, 32'h0000_0001);
    send_beat(ACT_GET, 32'h0000_0002);
    send_beat(ACT_GET, 32'h0000_0003);
    send_beat(ACT_UNKNOWN, 32'h0000_0000);
    // dirty unpinned slot gets evicted with writeback
    send_beat(ACT_RELEASE, 32'h8000_0000);
    send_beat(ACT_DIRTY, 32'h8000_0000);
    send_beat(ACT_GET, 32'h0000_0003);
    send_beat(ACT_RELEASE, 32'h0000_0003);
    send_beat(ACT_RELEASE, 32'h0000_0003);
    send_beat(ACT_RELEASE, 32'h0000_0000);
    send_beat(ACT_GET, 32'h0000_0000);

    send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(225);
    send_idle_pct = 81; recv_stall_pct = 0;  run_phase(225);
    send_idle_pct = 0;  recv_stall_pct = 81; run_phase(225);
    send_idle_pct = 37; recv_stall_pct = 37; run_phase(225);
    in_valid_i <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
